FILE: src/dcosl_pkg.sv
// ----------------------------------------------------------------------------
// dcosl_pkg
// Shared constants of the depth column obstacle speed limiter.
// ----------------------------------------------------------------------------
`default_nettype none

package dcosl_pkg;

  // Threshold registers and the column counters
  localparam int unsigned THR_W   = 10;
  localparam int unsigned COUNT_W = 11;

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned DIST_W     = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LOCAL_THRESHOLD  = 2'd0,
    CFG_GLOBAL_THRESHOLD = 2'd1,
    CFG_MIN_DISTANCE     = 2'd2,
    CFG_MAX_DISTANCE     = 2'd3
  } cfg_idx_t;

  localparam logic [THR_W-1:0]  LOCAL_THRESHOLD_RST  = 10'd3;
  localparam logic [THR_W-1:0]  GLOBAL_THRESHOLD_RST = 10'd3;
  localparam logic [DIST_W-1:0] MIN_DISTANCE_RST     = 16'd300;
  localparam logic [DIST_W-1:0] MAX_DISTANCE_RST     = 16'd2000;

endpackage

`default_nettype wire

FILE: src/dcosl_if.sv
// ----------------------------------------------------------------------------
// dcosl_in_if / dcosl_out_if
// Valid/ready channels for depth samples and per-frame speed results.
// ----------------------------------------------------------------------------
`default_nettype none

interface dcosl_in_if #(
  parameter int unsigned DEPTH_BITS = 16
);
  logic                  valid;
  logic                  ready;
  logic [DEPTH_BITS-1:0] depth_mm;
  logic                  column_end;
  logic                  frame_end;

  modport source (output valid, output depth_mm, output column_end, output frame_end,
                  input ready);
  modport sink   (input valid, input depth_mm, input column_end, input frame_end,
                  output ready);
endinterface

interface dcosl_out_if #(
  parameter int unsigned DEPTH_BITS = 16,
  parameter int unsigned SPEED_BITS = 16
);
  logic                  valid;
  logic                  ready;
  logic [SPEED_BITS-1:0] speed_fraction;
  logic                  obstacle_found;
  logic [DEPTH_BITS-1:0] obstacle_distance;

  modport source (output valid, output speed_fraction, output obstacle_found,
                  output obstacle_distance, input ready);
  modport sink   (input valid, input speed_fraction, input obstacle_found,
                  input obstacle_distance, output ready);
endinterface

`default_nettype wire

FILE: src/dcosl_front.sv
// ----------------------------------------------------------------------------
// dcosl_front
// Column scan: falling-run detection, hit column counting, obstacle declaration.
// ----------------------------------------------------------------------------
`default_nettype none

module dcosl_front
  import dcosl_pkg::*;
#(
  parameter int unsigned DEPTH_BITS = 16
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  dcosl_in_if.sink                   in_ch,
  input  wire logic [THR_W-1:0]      local_threshold,
  input  wire logic [THR_W-1:0]      global_threshold,
  input  wire logic                  q_full,
  output      logic                  q_push,
  output      logic [DEPTH_BITS:0]   q_data
);

  logic [DEPTH_BITS-1:0] prev_r, prev_nxt;
  logic [DEPTH_BITS-1:0] last_r, last_nxt;
  logic [DEPTH_BITS-1:0] found_r, found_nxt;
  logic [COUNT_W-1:0]    run_r, run_nxt;
  logic [COUNT_W-1:0]    hit_r, hit_nxt;
  logic                  flag_r, flag_nxt;
  logic                  skip_col_r, skip_col_nxt;
  logic                  skip_frm_r, skip_frm_nxt;

  logic accept, fe, ce, done;

  assign in_ch.ready = !q_full;
  assign accept      = in_ch.valid && !q_full;
  assign fe          = in_ch.frame_end;
  assign ce          = in_ch.column_end || in_ch.frame_end;

  always_comb begin
    prev_nxt     = prev_r;
    last_nxt     = last_r;
    found_nxt    = found_r;
    run_nxt      = run_r;
    hit_nxt      = hit_r;
    flag_nxt     = flag_r;
    skip_col_nxt = skip_col_r;
    skip_frm_nxt = skip_frm_r;
    done         = 1'b0;
    q_push       = 1'b0;
    q_data       = '0;

    if (accept) begin
      if (!skip_frm_r) begin
        if (skip_col_r) begin
          if (ce) begin
            skip_col_nxt = 1'b0;
          end
        end else begin
          last_nxt = in_ch.depth_mm;
          if (in_ch.depth_mm == '0) begin
            // noise ends the column
            done = 1'b1;
          end else begin
            if (in_ch.depth_mm < prev_r) begin
              if (run_r != '1) begin
                run_nxt = run_r + COUNT_W'(1);
              end
            end else begin
              run_nxt = '0;
            end
            if (run_nxt > {1'b0, local_threshold}) begin
              run_nxt  = '0;
              if (hit_r != '1) begin
                hit_nxt = hit_r + COUNT_W'(1);
              end
              flag_nxt = 1'b1;
              done     = 1'b1;
            end else begin
              prev_nxt = in_ch.depth_mm;
            end
          end
          if (done || ce) begin
            if (!flag_nxt) begin
              hit_nxt = '0;
            end
            flag_nxt = 1'b0;
            if (hit_nxt >= {1'b0, global_threshold}) begin
              found_nxt    = in_ch.depth_mm;
              skip_frm_nxt = 1'b1;
            end else begin
              found_nxt = '0;
            end
            if (!ce && !skip_frm_nxt) begin
              skip_col_nxt = 1'b1;
            end
          end
        end
      end

      if (fe) begin
        // hand the frame summary to the back end, then clear the frame
        q_push       = 1'b1;
        q_data       = {skip_frm_nxt, found_nxt};
        prev_nxt     = '0;
        run_nxt      = '0;
        hit_nxt      = '0;
        flag_nxt     = 1'b0;
        skip_col_nxt = 1'b0;
        skip_frm_nxt = 1'b0;
        found_nxt    = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r     <= '0;
      last_r     <= '0;
      found_r    <= '0;
      run_r      <= '0;
      hit_r      <= '0;
      flag_r     <= 1'b0;
      skip_col_r <= 1'b0;
      skip_frm_r <= 1'b0;
    end else begin
      prev_r     <= prev_nxt;
      last_r     <= last_nxt;
      found_r    <= found_nxt;
      run_r      <= run_nxt;
      hit_r      <= hit_nxt;
      flag_r     <= flag_nxt;
      skip_col_r <= skip_col_nxt;
      skip_frm_r <= skip_frm_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: src/dcosl_fifo.sv
// ----------------------------------------------------------------------------
// dcosl_fifo
// Two-entry queue of frame summaries between the scan and the speed scaler.
// ----------------------------------------------------------------------------
`default_nettype none

module dcosl_fifo #(
  parameter int unsigned WIDTH = 17
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] push_data,
  input  wire logic             pop,
  output      logic             full,
  output      logic             not_empty,
  output      logic [WIDTH-1:0] pop_data
);

  logic [WIDTH-1:0] mem_r [2];
  logic             wr_ptr_r, wr_ptr_nxt;
  logic             rd_ptr_r, rd_ptr_nxt;
  logic [1:0]       cnt_r, cnt_nxt;

  assign full      = (cnt_r == 2'd2);
  assign not_empty = (cnt_r != 2'd0);
  assign pop_data  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop  ? !rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: src/dcosl_back.sv
// ----------------------------------------------------------------------------
// dcosl_back
// Speed scaler: maps the obstacle distance between min and max to a fraction,
// with a one-bit-per-cycle restoring divider.
// ----------------------------------------------------------------------------
`default_nettype none

module dcosl_back
  import dcosl_pkg::*;
#(
  parameter int unsigned DEPTH_BITS = 16,
  parameter int unsigned SPEED_BITS = 16
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  rec_valid,
  input  wire logic [DEPTH_BITS:0]   rec_data,
  output      logic                  rec_pop,
  input  wire logic [DEPTH_BITS-1:0] min_distance,
  input  wire logic [DEPTH_BITS-1:0] max_distance,
  dcosl_out_if.source                out_ch
);

  localparam int unsigned NW    = DEPTH_BITS + SPEED_BITS;
  localparam int unsigned CNT_W = $clog2(NW);
  localparam logic [SPEED_BITS-1:0] FULL = '1;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_DIV  = 3'b010,
    ST_OUT  = 3'b100
  } bk_state_t;

  bk_state_t             state_r, state_nxt;
  logic [NW-1:0]         num_r, num_nxt;
  logic [DEPTH_BITS-1:0] rem_r, rem_nxt;
  logic [DEPTH_BITS-1:0] div_r, div_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic [SPEED_BITS-1:0] speed_r, speed_nxt;
  logic                  found_r, found_nxt;
  logic [DEPTH_BITS-1:0] dist_r, dist_nxt;

  logic                  rec_found;
  logic [DEPTH_BITS-1:0] rec_dist;
  logic [DEPTH_BITS-1:0] diff;
  logic [NW-1:0]         diff_ext;
  logic [DEPTH_BITS:0]   rem_try;
  logic                  q_bit;
  logic [NW-1:0]         num_step;

  assign rec_found = rec_data[DEPTH_BITS];
  assign rec_dist  = rec_data[DEPTH_BITS-1:0];
  assign diff      = rec_dist - min_distance;
  assign diff_ext  = NW'(diff);

  // one restoring division step
  assign rem_try  = {rem_r, num_r[NW-1]};
  assign q_bit    = (rem_try >= {1'b0, div_r});
  assign num_step = {num_r[NW-2:0], q_bit};

  assign out_ch.valid             = (state_r == ST_OUT);
  assign out_ch.speed_fraction    = speed_r;
  assign out_ch.obstacle_found    = found_r;
  assign out_ch.obstacle_distance = dist_r;

  always_comb begin
    state_nxt = state_r;
    num_nxt   = num_r;
    rem_nxt   = rem_r;
    div_nxt   = div_r;
    cnt_nxt   = cnt_r;
    speed_nxt = speed_r;
    found_nxt = found_r;
    dist_nxt  = dist_r;
    rec_pop   = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (rec_valid) begin
          rec_pop   = 1'b1;
          found_nxt = rec_found;
          dist_nxt  = rec_found ? rec_dist : '0;
          priority if (!rec_found) begin
            speed_nxt = FULL;
            state_nxt = ST_OUT;
          end else if (rec_dist > max_distance) begin
            speed_nxt = FULL;
            state_nxt = ST_OUT;
          end else if (rec_dist <= min_distance) begin
            speed_nxt = '0;
            state_nxt = ST_OUT;
          end else begin
            // (d - min) * FULL as a shift and subtract
            num_nxt   = (diff_ext << SPEED_BITS) - diff_ext;
            rem_nxt   = '0;
            div_nxt   = max_distance - min_distance;
            cnt_nxt   = CNT_W'(NW - 1);
            state_nxt = ST_DIV;
          end
        end
      end
      ST_DIV: begin
        num_nxt = num_step;
        rem_nxt = q_bit ? DEPTH_BITS'(rem_try - {1'b0, div_r}) : rem_try[DEPTH_BITS-1:0];
        if (cnt_r == '0) begin
          speed_nxt = num_step[SPEED_BITS-1:0];
          state_nxt = ST_OUT;
        end else begin
          cnt_nxt = cnt_r - CNT_W'(1);
        end
      end
      ST_OUT: begin
        if (out_ch.ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    num_r   <= num_nxt;
    rem_r   <= rem_nxt;
    div_r   <= div_nxt;
    cnt_r   <= cnt_nxt;
    speed_r <= speed_nxt;
    found_r <= found_nxt;
    dist_r  <= dist_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: src/depth_column_obstacle_speed_limiter.sv
// ----------------------------------------------------------------------------
// depth_column_obstacle_speed_limiter
// Column-wise depth scan that declares obstacles and limits speed per frame.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch   carries depth samples, column by column, bottom row upward, with
//           column_end and frame_end marks. One transaction per cycle is
//           taken while the summary queue has room.
//   out_ch  gives one transaction per frame, after the frame_end sample:
//           speed fraction, obstacle flag and obstacle distance.
//   cfg_*   writes thresholds and distances; write only while idle.
// Path: a frame summary is written to the summary queue when its frame_end
//   sample is accepted; the back end then moves it to out_ch directly when
//   no scaling is needed, or through the serial divider when the distance
//   lies between min and max; the serial divider gives one quotient bit per
//   cycle.
// Stall: a stalled receiver holds the result; the two-entry summary queue
//   absorbs further frames, then in_ch.ready drops.
// Reset: synchronous, active low; clears the scan state and reloads the
//   register defaults (3, 3, 300 mm, 2000 mm).
// ----------------------------------------------------------------------------
`default_nettype none

module depth_column_obstacle_speed_limiter
  import dcosl_pkg::*;
#(
  parameter int unsigned DEPTH_BITS = 16,
  parameter int unsigned SPEED_BITS = 16
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  dcosl_in_if.sink                   in_ch,
  dcosl_out_if.source                out_ch,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int unsigned CFG_DW = (DEPTH_BITS < DIST_W) ? DEPTH_BITS : DIST_W;

  logic [THR_W-1:0]  local_thr_r;
  logic [THR_W-1:0]  global_thr_r;
  logic [CFG_DW-1:0] min_dist_r;
  logic [CFG_DW-1:0] max_dist_r;

  logic                  q_full, q_push, q_pop, q_not_empty;
  logic [DEPTH_BITS:0]   q_wdata, q_rdata;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      local_thr_r  <= LOCAL_THRESHOLD_RST;
      global_thr_r <= GLOBAL_THRESHOLD_RST;
      min_dist_r   <= CFG_DW'(MIN_DISTANCE_RST);
      max_dist_r   <= CFG_DW'(MAX_DISTANCE_RST);
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_idx))
        CFG_LOCAL_THRESHOLD:  local_thr_r  <= cfg_data[THR_W-1:0];
        CFG_GLOBAL_THRESHOLD: global_thr_r <= cfg_data[THR_W-1:0];
        CFG_MIN_DISTANCE:     min_dist_r   <= cfg_data[CFG_DW-1:0];
        CFG_MAX_DISTANCE:     max_dist_r   <= cfg_data[CFG_DW-1:0];
        default: ;
      endcase
    end
  end

  dcosl_front #(
    .DEPTH_BITS (DEPTH_BITS)
  ) u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_ch            (in_ch),
    .local_threshold  (local_thr_r),
    .global_threshold (global_thr_r),
    .q_full           (q_full),
    .q_push           (q_push),
    .q_data           (q_wdata)
  );

  dcosl_fifo #(
    .WIDTH (DEPTH_BITS + 1)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_wdata),
    .pop       (q_pop),
    .full      (q_full),
    .not_empty (q_not_empty),
    .pop_data  (q_rdata)
  );

  dcosl_back #(
    .DEPTH_BITS (DEPTH_BITS),
    .SPEED_BITS (SPEED_BITS)
  ) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .rec_valid    (q_not_empty),
    .rec_data     (q_rdata),
    .rec_pop      (q_pop),
    .min_distance (DEPTH_BITS'(min_dist_r)),
    .max_distance (DEPTH_BITS'(max_dist_r)),
    .out_ch       (out_ch)
  );

endmodule

`default_nettype wire

FILE: tb/tb_depth_column_obstacle_speed_limiter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_depth_column_obstacle_speed_limiter
// Depth columns go in through a valid/ready channel with random gaps. A scan
// model in this file follows the columns and predicts each frame result. The
// speed results, taken with random back-pressure, are compared field by
// field. A short directed table comes first, then random frames under several
// register settings.
// ----------------------------------------------------------------------------
module tb_depth_column_obstacle_speed_limiter;
  import dcosl_pkg::*;

  localparam int unsigned DEPTH_W       = 16;
  localparam int unsigned SPEED_W       = 16;
  localparam int unsigned SETTLE_CYCLES = DEPTH_W + SPEED_W + 8;
  localparam int unsigned PHASES        = 7;
  localparam int unsigned PHASE_ITEMS   = 120;
  localparam int unsigned DIR_ROWS      = 32;
  localparam logic [SPEED_W-1:0] SPEED_FULL = '1;
  localparam logic [COUNT_W-1:0] COUNT_SAT  = '1;

  typedef struct packed {
    logic [SPEED_W-1:0] speed;
    logic               found;
    logic [DEPTH_W-1:0] dist_mm;
  } frame_res_t;

  typedef enum logic [1:0] {
    ROW_PRED,
    ROW_TYPED,
    ROW_CFG
  } row_kind_t;

  typedef struct packed {
    row_kind_t          kind;
    cfg_idx_t           idx;
    logic [DEPTH_W-1:0] value;
    logic               col_end;
    logic               frm_end;
    frame_res_t         want;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;

  dcosl_in_if  #(.DEPTH_BITS(DEPTH_W)) in_if ();
  dcosl_out_if #(.DEPTH_BITS(DEPTH_W), .SPEED_BITS(SPEED_W)) out_if ();

  depth_column_obstacle_speed_limiter #(
    .DEPTH_BITS(DEPTH_W),
    .SPEED_BITS(SPEED_W)
  ) dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_if),
    .out_ch  (out_if),
    .cfg_we  (cfg_we),
    .cfg_idx (cfg_idx),
    .cfg_data(cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  initial begin
    #2000000;
    $display("simulation failed");
    $finish;
  end

  // Register copies
  logic [THR_W-1:0]   loc_thr;
  logic [THR_W-1:0]   glob_thr;
  logic [DEPTH_W-1:0] near_mm;
  logic [DEPTH_W-1:0] far_mm;

  // Scan state
  logic [DEPTH_W-1:0] prev_mm;
  logic [DEPTH_W-1:0] last_mm;
  logic [COUNT_W-1:0] fall_run;
  logic [COUNT_W-1:0] hit_cols;
  logic               col_hit;
  logic               skip_col;
  logic               skip_frame;
  logic [DEPTH_W-1:0] found_mm;

  frame_res_t  speed_due[$];
  int unsigned errors;
  int unsigned sent_items;
  bit          in_calm;
  bit          out_calm;

  // Directed rows: extremes, noise, carried runs, early column end, min above max
  dir_row_t dir_tab [DIR_ROWS] = '{
    '{ROW_TYPED, CFG_LOCAL_THRESHOLD, 16'hFFFF, 1'b0, 1'b1, '{SPEED_FULL, 1'b0, 16'd0}},
    '{ROW_TYPED, CFG_LOCAL_THRESHOLD, 16'd0,    1'b0, 1'b1, '{SPEED_FULL, 1'b0, 16'd0}},
    '{ROW_CFG,   CFG_LOCAL_THRESHOLD, 16'd0,    1'b0, 1'b0, '0},
    '{ROW_CFG,   CFG_GLOBAL_THRESHOLD, 16'd1,   1'b0, 1'b0, '0},
    '{ROW_PRED,  CFG_LOCAL_THRESHOLD, 16'd1000, 1'b0, 1'b0, '0},
    '{ROW_PRED,  CFG_LOCAL_THRESHOLD, 16'd999,  1'b0, 1'b0, '0},
    '{ROW_PRED,  CFG_LOCAL_THRESHOLD, 16'd5,    1'b1, 1'b0, '0},
    '{ROW_PRED,  CFG_LOCAL_THRESHOLD, 16'd7,    1'b0, 1'b1, '0},
    '{ROW_PRED,  CFG_LOCAL_THRESHOLD, 16'd2000, 1'b0, 1'b0, '0},
    '{ROW_PRED,  CFG_LOCAL_THRESHOLD, 16'd300,  1'b0, 1'b0, '0},
    '{ROW_TYPED, CFG_LOCAL_THRESHOLD, 16'd1,    1'b0, 1'b1, '{16'd0, 1'b1, 16'd300}},
    '{ROW_PRED,  CFG_LOCAL_THRESHOLD, 16'hFFFF, 1'b0, 1'b0, '0},
    '{ROW_PRED,  CFG_LOCAL_THRESHOLD, 16'hFFFE, 1'b1, 1'b0, '0},
    '{ROW_TYPED, CFG_LOCAL_THRESHOLD, 16'd0,    1'b1, 1'b1, '{SPEED_FULL, 1'b1, 16'hFFFE}},
    '{ROW_CFG,   CFG_GLOBAL_THRESHOLD, 16'd0,   1'b0, 1'b0, '0},
    '{ROW_TYPED, CFG_LOCAL_THRESHOLD, 16'd0,    1'b0, 1'b1, '{16'd0, 1'b1, 16'd0}},
    '{ROW_CFG,   CFG_LOCAL_THRESHOLD, 16'd1,    1'b0, 1'b0, '0},
    '{ROW_CFG,   CFG_GLOBAL_THRESHOLD, 16'd2,   1'b0, 1'b0, '0},
    '{ROW_PRED,  CFG_LOCAL_THRESHOLD, 16'd500,  1'b0, 1'b0, '0},
    '{ROW_PRED,  CFG_LOCAL_THRESHOLD, 16'd400,  1'b1, 1'b0, '0},
    '{ROW_PRED,  CFG_LOCAL_THRESHOLD, 16'd300,  1'b0, 1'b0, '0},
    '{ROW_PRED,  CFG_LOCAL_THRESHOLD, 16'd9999, 1'b0, 1'b0, '0},
    '{ROW_PRED,  CFG_LOCAL_THRESHOLD, 16'd9999, 1'b1, 1'b0, '0},
    '{ROW_PRED,  CFG_LOCAL_THRESHOLD, 16'd200,  1'b0, 1'b0, '0},
    '{ROW_PRED,  CFG_LOCAL_THRESHOLD, 16'd100,  1'b0, 1'b0, '0},
    '{ROW_PRED,  CFG_LOCAL_THRESHOLD, 16'd4242, 1'b0, 1'b1, '0},
    '{ROW_CFG,   CFG_LOCAL_THRESHOLD, 16'd0,    1'b0, 1'b0, '0},
    '{ROW_CFG,   CFG_GLOBAL_THRESHOLD, 16'd1,   1'b0, 1'b0, '0},
    '{ROW_CFG,   CFG_MIN_DISTANCE, 16'hFFFF,    1'b0, 1'b0, '0},
    '{ROW_CFG,   CFG_MAX_DISTANCE, 16'd0,       1'b0, 1'b0, '0},
    '{ROW_PRED,  CFG_LOCAL_THRESHOLD, 16'd50,   1'b0, 1'b0, '0},
    '{ROW_TYPED, CFG_LOCAL_THRESHOLD, 16'd40,   1'b0, 1'b1, '{SPEED_FULL, 1'b1, 16'd40}}
  };

  // local, global, min, max for each random phase
  int unsigned phase_set [PHASES][4] = '{
    '{2, 2, 300, 2000},
    '{0, 1, 1000, 3000},
    '{1, 3, 0, 65535},
    '{1023, 1023, 65535, 0},
    '{3, 0, 500, 500},
    '{0, 2, 0, 0},
    '{1, 1, 2500, 400}
  };

  function automatic void clear_frame();
    prev_mm    = '0;
    fall_run   = '0;
    hit_cols   = '0;
    col_hit    = 1'b0;
    skip_col   = 1'b0;
    skip_frame = 1'b0;
    found_mm   = '0;
  endfunction

  function automatic void restore_defaults();
    loc_thr  = LOCAL_THRESHOLD_RST;
    glob_thr = GLOBAL_THRESHOLD_RST;
    near_mm  = MIN_DISTANCE_RST;
    far_mm   = MAX_DISTANCE_RST;
    last_mm  = '0;
    clear_frame();
  endfunction

  function automatic logic [SPEED_W-1:0] speed_for(input logic [DEPTH_W-1:0] d);
    longint unsigned num;
    longint unsigned span;
    if (d > far_mm) return SPEED_FULL;
    if (d <= near_mm) return '0;
    num  = d - near_mm;
    span = far_mm - near_mm;
    num  = num * SPEED_FULL;
    return SPEED_W'(num / span);
  endfunction

  // Advance the scan by one sample; true when the sample closes a frame
  function automatic bit scan_sample(input logic [DEPTH_W-1:0] d, input logic col_mark,
                                     input logic fe, output frame_res_t res);
    logic ce;
    logic col_done;
    ce       = col_mark | fe;
    col_done = 1'b0;
    res      = '0;
    if (!skip_frame) begin
      if (skip_col) begin
        if (ce) skip_col = 1'b0;
      end else begin
        last_mm = d;
        if (d == '0) begin
          col_done = 1'b1;
        end else begin
          if (d < prev_mm) begin
            if (fall_run != COUNT_SAT) fall_run = fall_run + 1'b1;
          end else begin
            fall_run = '0;
          end
          if (fall_run > COUNT_W'(loc_thr)) begin
            fall_run = '0;
            if (hit_cols != COUNT_SAT) hit_cols = hit_cols + 1'b1;
            col_hit  = 1'b1;
            col_done = 1'b1;
          end else begin
            prev_mm = d;
          end
        end
        if (col_done || ce) begin
          if (!col_hit) hit_cols = '0;
          col_hit = 1'b0;
          if (hit_cols >= COUNT_W'(glob_thr)) begin
            found_mm   = last_mm;
            skip_frame = 1'b1;
          end else begin
            found_mm = '0;
          end
          if (!ce && !skip_frame) skip_col = 1'b1;
        end
      end
    end
    if (!fe) return 1'b0;
    if (skip_frame) begin
      res.speed   = speed_for(found_mm);
      res.found   = 1'b1;
      res.dist_mm = found_mm;
    end else begin
      res.speed   = SPEED_FULL;
      res.found   = 1'b0;
      res.dist_mm = '0;
    end
    clear_frame();
    return 1'b1;
  endfunction

  // Called at a falling edge; returns at a falling edge
  task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we   = 1'b1;
    cfg_idx  = idx;
    cfg_data = val;
    @(negedge clk);
    cfg_we = 1'b0;
    case (idx)
      CFG_LOCAL_THRESHOLD:  loc_thr  = val[THR_W-1:0];
      CFG_GLOBAL_THRESHOLD: glob_thr = val[THR_W-1:0];
      CFG_MIN_DISTANCE:     near_mm  = val;
      CFG_MAX_DISTANCE:     far_mm   = val;
      default: ;
    endcase
  endtask

  // Drain all pending frames, then allow for a divide still in flight
  task automatic settle_idle();
    in_if.valid = 1'b0;
    while (speed_due.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic drive_sample(input logic [DEPTH_W-1:0] d, input logic ce, input logic fe,
                              output bit has_res, output frame_res_t res);
    int unsigned gap;
    gap = in_calm ? 0 : $urandom_range(0, 12);
    if (gap != 0) begin
      in_if.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_if.valid      = 1'b1;
    in_if.depth_mm   = d;
    in_if.column_end = ce;
    in_if.frame_end  = fe;
    do @(posedge clk); while (!in_if.ready);
    has_res    = scan_sample(d, ce, fe, res);
    sent_items = sent_items + 1;
    @(negedge clk);
  endtask

  // A frame of columns, each mostly falling with the odd rise, jump or noise sample
  task automatic send_frame();
    int unsigned ncols;
    int unsigned len;
    int          level;
    logic [DEPTH_W-1:0] d;
    logic        ce;
    logic        fe;
    bit          has_res;
    frame_res_t  res;
    ncols = $urandom_range(1, 6);
    for (int c = 0; c < ncols; c++) begin
      len = $urandom_range(1, 10);
      case ($urandom_range(0, 7))
        0:       level = $urandom_range(1, 65535);
        1:       level = $urandom_range(1, 500);
        default: level = $urandom_range(100, 5000);
      endcase
      for (int s = 0; s < len; s++) begin
        case ($urandom_range(0, 19))
          0: d = '0;
          1: d = DEPTH_W'($urandom_range(0, 65535));
          2: begin
            level = level + $urandom_range(0, 500);
            if (level > 65535) level = 65535;
            d = DEPTH_W'(level);
          end
          default: begin
            level = level - $urandom_range(0, 200);
            if (level < 1) level = 1;
            d = DEPTH_W'(level);
          end
        endcase
        fe = (s == len - 1) && (c == ncols - 1);
        ce = fe ? logic'($urandom_range(0, 1)) : (s == len - 1);
        drive_sample(d, ce, fe, has_res, res);
        if (has_res) speed_due.push_back(res);
      end
    end
  endtask

  task automatic send_noise();
    int unsigned n;
    bit          has_res;
    frame_res_t  res;
    n = $urandom_range(1, 5);
    repeat (n) begin
      drive_sample(DEPTH_W'($urandom_range(0, 65535)), logic'($urandom_range(0, 1)),
                   $urandom_range(0, 5) == 0, has_res, res);
      if (has_res) speed_due.push_back(res);
    end
  endtask

  // Result side: random back-pressure and the comparison
  initial begin
    int unsigned stall;
    frame_res_t  got;
    frame_res_t  want;
    out_if.ready = 1'b0;
    while (rst_n !== 1'b1) @(negedge clk);
    forever begin
      stall = out_calm ? 0 : $urandom_range(0, 12);
      if (stall != 0) begin
        out_if.ready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_if.ready = 1'b1;
      do @(posedge clk); while (!out_if.valid);
      got.speed   = out_if.speed_fraction;
      got.found   = out_if.obstacle_found;
      got.dist_mm = out_if.obstacle_distance;
      if (speed_due.size() == 0) begin
        errors = errors + 1;
        if (errors <= 10)
          $display("unexpected result: speed %0d found %0d dist %0d",
                   got.speed, got.found, got.dist_mm);
      end else begin
        want = speed_due.pop_front();
        if (got.speed !== want.speed || got.found !== want.found ||
            got.dist_mm !== want.dist_mm) begin
          errors = errors + 1;
          if (errors <= 10)
            $display({"result mismatch: expected speed %0d found %0d dist %0d, ",
                      "got speed %0d found %0d dist %0d"},
                     want.speed, want.found, want.dist_mm,
                     got.speed, got.found, got.dist_mm);
        end
      end
      @(negedge clk);
    end
  end

  initial begin
    bit         has_res;
    frame_res_t res;
    errors           = 0;
    sent_items       = 0;
    in_calm          = 1'b0;
    out_calm         = 1'b0;
    rst_n            = 1'b0;
    in_if.valid      = 1'b0;
    in_if.depth_mm   = '0;
    in_if.column_end = 1'b0;
    in_if.frame_end  = 1'b0;
    cfg_we           = 1'b0;
    cfg_idx          = CFG_LOCAL_THRESHOLD;
    cfg_data         = '0;
    restore_defaults();
    repeat (5) @(negedge clk);
    rst_n = 1'b1;

    for (int r = 0; r < DIR_ROWS; r++) begin
      if (dir_tab[r].kind == ROW_CFG) begin
        settle_idle();
        write_reg(dir_tab[r].idx, dir_tab[r].value);
      end else begin
        drive_sample(dir_tab[r].value, dir_tab[r].col_end, dir_tab[r].frm_end, has_res, res);
        if (dir_tab[r].kind == ROW_TYPED) speed_due.push_back(dir_tab[r].want);
        else if (has_res) speed_due.push_back(res);
      end
    end

    for (int p = 0; p < PHASES; p++) begin
      settle_idle();
      write_reg(CFG_LOCAL_THRESHOLD, CFG_DATA_W'(phase_set[p][0]));
      write_reg(CFG_GLOBAL_THRESHOLD, CFG_DATA_W'(phase_set[p][1]));
      write_reg(CFG_MIN_DISTANCE, CFG_DATA_W'(phase_set[p][2]));
      write_reg(CFG_MAX_DISTANCE, CFG_DATA_W'(phase_set[p][3]));
      in_calm  = $urandom_range(0, 3) == 0;
      out_calm = $urandom_range(0, 3) == 0;
      sent_items = 0;
      while (sent_items < PHASE_ITEMS) begin
        if ($urandom_range(0, 9) == 0) send_noise();
        else send_frame();
        // hold the sender until the result side has caught up
        if ($urandom_range(0, 19) == 0) begin
          in_if.valid = 1'b0;
          while (speed_due.size() != 0) @(negedge clk);
        end
      end
      // close any frame left open by noise before the next register change
      send_frame();
    end

    settle_idle();
    if (errors == 0 && speed_due.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

FILE: sim.f
src/dcosl_pkg.sv
src/dcosl_if.sv
src/dcosl_front.sv
src/dcosl_fifo.sv
src/dcosl_back.sv
src/depth_column_obstacle_speed_limiter.sv
tb/tb_depth_column_obstacle_speed_limiter.sv
